// ===== src/irb_pkg.sv =====
// shared constants, types and the cordic arctangent table for the ir beacon receiver board
// no dependencies
package irb_pkg;

  localparam int ANGLE_BITS      = 16;
  localparam int CORDIC_STEPS    = 24;
  localparam int STEPS_PER_STAGE = 4;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
  // deltas scaled by 2^24 plus cordic growth and sign
  localparam int CORDIC_W        = 43;
  localparam int PADDR_W         = 4;

  // reply kinds
  localparam logic [1:0] KIND_PONG   = 2'd0;
  localparam logic [1:0] KIND_STATE  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // command codes
  localparam logic [7:0] CMD_PING  = 8'd0;
  localparam logic [7:0] CMD_STATE = 8'd1;
  localparam logic [7:0] CMD_AUTO  = 8'd2;

  localparam logic [7:0] PING_BYTE = 8'h55;
  localparam logic [7:0] PONG_BYTE = 8'hAA;
  localparam logic [7:0] AUTO_ON   = 8'd1;

  // register indexes
  localparam logic [1:0] REG_PERIOD  = 2'd0;
  localparam logic [1:0] REG_NEAR    = 2'd1;
  localparam logic [1:0] REG_CLOSER  = 2'd2;
  localparam logic [1:0] REG_CLOSEST = 2'd3;

  localparam logic [15:0] PERIOD_RESET  = 16'd200;
  localparam logic [15:0] NEAR_RESET    = 16'd1500;
  localparam logic [15:0] CLOSER_RESET  = 16'd1000;
  localparam logic [15:0] CLOSEST_RESET = 16'd500;

  // item travelling alongside the cordic pipeline
  typedef struct packed {
    logic        vld;
    logic [1:0]  kind;
    logic        beacon;
    logic [15:0] heading;
    logic [30:0] fwd_sq;
    logic [30:0] side_sq;
    logic        near;
    logic        closer;
    logic        closest;
  } irb_side_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] cordic_atan(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// ===== src/irb_cordic.sv =====
// pipelined vectoring cordic giving the beacon bearing as a 32-bit binary angle
// depends on irb_pkg
module irb_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] fwd,
  input  logic signed [15:0] side,
  output logic [31:0]        bearing
);
  import irb_pkg::*;

  logic signed [CORDIC_W-1:0] x_in [CORDIC_STAGES];
  logic signed [CORDIC_W-1:0] y_in [CORDIC_STAGES];
  logic [31:0]                z_in [CORDIC_STAGES];
  logic                       zero_in [CORDIC_STAGES];

  logic signed [CORDIC_W-1:0] x_q [CORDIC_STAGES];
  logic signed [CORDIC_W-1:0] y_q [CORDIC_STAGES];
  logic [31:0]                z_q [CORDIC_STAGES];
  logic                       zero_q [CORDIC_STAGES];

  logic signed [CORDIC_W-1:0] x_scaled;
  logic signed [CORDIC_W-1:0] y_scaled;

  // scale by 2^24, fold the left half plane over with a half turn start
  always_comb begin
    x_scaled = {{(CORDIC_W-40){fwd[15]}}, fwd, 24'd0};
    y_scaled = {{(CORDIC_W-40){side[15]}}, side, 24'd0};
    if (fwd[15]) begin
      x_in[0] = -x_scaled;
      y_in[0] = -y_scaled;
      z_in[0] = 32'h80000000;
    end else begin
      x_in[0] = x_scaled;
      y_in[0] = y_scaled;
      z_in[0] = 32'd0;
    end
    zero_in[0] = (fwd == 16'sd0) && (side == 16'sd0);
  end

  for (genvar s = 1; s < CORDIC_STAGES; s++) begin : g_link
    assign x_in[s]    = x_q[s-1];
    assign y_in[s]    = y_q[s-1];
    assign z_in[s]    = z_q[s-1];
    assign zero_in[s] = zero_q[s-1];
  end

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    logic signed [CORDIC_W-1:0] xv;
    logic signed [CORDIC_W-1:0] yv;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic [31:0]                zv;

    always_comb begin
      xv = x_in[s];
      yv = y_in[s];
      zv = z_in[s];
      xs = '0;
      ys = '0;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        xs = xv >>> (s * STEPS_PER_STAGE + k);
        ys = yv >>> (s * STEPS_PER_STAGE + k);
        if (!yv[CORDIC_W-1]) begin
          xv = xv + ys;
          yv = yv - xs;
          zv = zv + cordic_atan(5'(s * STEPS_PER_STAGE + k));
        end else begin
          xv = xv - ys;
          yv = yv + xs;
          zv = zv - cordic_atan(5'(s * STEPS_PER_STAGE + k));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_q[s]    <= xv;
        y_q[s]    <= yv;
        z_q[s]    <= zv;
        zero_q[s] <= zero_in[s];
      end
    end
  end

  // both deltas zero give bearing zero
  assign bearing = zero_q[CORDIC_STAGES-1] ? 32'd0 : z_q[CORDIC_STAGES-1];

endmodule

// ===== src/ir_beacon_receiver_board_core.sv =====
// top level of the ir beacon receiver board: command and tick handling, ring tests, masks
// depends on irb_pkg and irb_cordic
//
// usage:
//   input channel (in_valid/in_ready) carries one command frame or time tick per
//   transaction; output channel (out_valid/out_ready) carries at most one reply per
//   input transaction, in order
//   replies: pong, receiver state (two bitmask bytes) or frame rejected; auto-send
//   frames and ticks that do not fire give no reply
//   throughput: one input transaction per cycle while the output side takes replies
//   pipeline: a reply passes the input register, 6 cordic stages of 4 iterations
//   each and the output register; the cordic chain sets its depth
//   auto-send and tick accounting are decided at the input transaction itself, so
//   back-to-back ticks see each other's effect
//   stall: the whole pipeline, input register to reply register, holds while a reply
//   waits on out_ready; in_ready is low only then
//   reset (rst, synchronous): auto-send off, elapsed sum zero, registers at their
//   defaults, pipeline empty
//   apb port: registers at byte addresses 0, 4, 8, 12 (period, near, closer, closest
//   ring), pready always high; write only while the block is idle
module ir_beacon_receiver_board_core (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic [7:0]                   command_code,
  input  logic [7:0]                   data_count,
  input  logic [7:0]                   first_data,
  input  logic [15:0]                  elapsed_ms,
  input  logic                         beacon_present,
  input  logic signed [15:0]           delta_forward,
  input  logic signed [15:0]           delta_side,
  input  logic [15:0]                  robot_heading,
  // output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   reply_kind,
  output logic [1:0]                   byte_count,
  output logic [7:0]                   payload_low,
  output logic [7:0]                   payload_high,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [irb_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import irb_pkg::*;

  // configuration registers and their squares
  logic [15:0] report_period_ms;
  logic [15:0] near_ring_mm;
  logic [15:0] closer_ring_mm;
  logic [15:0] closest_ring_mm;
  logic [31:0] near_sq;
  logic [31:0] closer_sq;
  logic [31:0] closest_sq;
  logic [31:0] wdata_sq;
  logic        cfg_write;

  // control state
  logic        auto_send_on;
  logic        auto_send_on_next;
  logic [31:0] time_since_report;
  logic [31:0] time_since_report_next;

  logic        advance;
  logic        accept;

  // decision at the input transaction
  logic [32:0] time_sum;
  logic [31:0] time_sat;
  logic        fire;
  logic        has_result;
  logic [1:0]  kind_next;

  // input register
  logic               s1_vld;
  logic [1:0]         s1_kind;
  logic               s1_beacon;
  logic [15:0]        s1_heading;
  logic signed [15:0] s1_fwd;
  logic signed [15:0] s1_side;
  logic signed [31:0] fwd_prod;
  logic signed [31:0] side_prod;

  irb_side_t   side_q [CORDIC_STAGES];
  logic [31:0] dist_sq;

  // bearing and mask
  logic [31:0]           bearing;
  logic [31:0]           heading_w;
  logic [ANGLE_BITS-1:0] rel_angle;
  logic [3:0]            centre;
  logic [15:0]           pattern;
  logic [31:0]           rotated;
  logic [15:0]           mask;
  irb_side_t             last;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign wdata_sq  = 32'(pwdata[15:0]) * 32'(pwdata[15:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      report_period_ms <= PERIOD_RESET;
      near_ring_mm     <= NEAR_RESET;
      closer_ring_mm   <= CLOSER_RESET;
      closest_ring_mm  <= CLOSEST_RESET;
      near_sq          <= 32'(NEAR_RESET) * 32'(NEAR_RESET);
      closer_sq        <= 32'(CLOSER_RESET) * 32'(CLOSER_RESET);
      closest_sq       <= 32'(CLOSEST_RESET) * 32'(CLOSEST_RESET);
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_PERIOD: begin
          report_period_ms <= pwdata[15:0];
        end
        REG_NEAR: begin
          near_ring_mm <= pwdata[15:0];
          near_sq      <= wdata_sq;
        end
        REG_CLOSER: begin
          closer_ring_mm <= pwdata[15:0];
          closer_sq      <= wdata_sq;
        end
        REG_CLOSEST: begin
          closest_ring_mm <= pwdata[15:0];
          closest_sq      <= wdata_sq;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PERIOD:  prdata = 32'(report_period_ms);
      REG_NEAR:    prdata = 32'(near_ring_mm);
      REG_CLOSER:  prdata = 32'(closer_ring_mm);
      REG_CLOSEST: prdata = 32'(closest_ring_mm);
      default:     prdata = 32'd0;
    endcase
  end

  // pipeline moves whenever the reply register is free or being emptied
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  // saturating elapsed-time sum, report once it strictly exceeds the period
  assign time_sum = {1'b0, time_since_report} + 33'(elapsed_ms);
  assign time_sat = time_sum[32] ? 32'hFFFFFFFF : time_sum[31:0];
  assign fire     = time_sat > 32'(report_period_ms);

  always_comb begin
    auto_send_on_next      = auto_send_on;
    time_since_report_next = time_since_report;
    has_result             = 1'b0;
    kind_next              = KIND_REJECT;
    if (mode) begin
      if (auto_send_on) begin
        time_since_report_next = fire ? 32'd0 : time_sat;
        has_result             = fire;
        kind_next              = KIND_STATE;
      end
    end else if (command_code == CMD_PING && data_count == 8'd1
                 && first_data == PING_BYTE) begin
      has_result = 1'b1;
      kind_next  = KIND_PONG;
    end else if (command_code == CMD_STATE && data_count == 8'd1) begin
      has_result = 1'b1;
      kind_next  = KIND_STATE;
    end else if (command_code == CMD_AUTO && data_count == 8'd1) begin
      auto_send_on_next = (first_data == AUTO_ON);
    end else begin
      // malformed frame
      has_result = 1'b1;
      kind_next  = KIND_REJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_send_on      <= 1'b0;
      time_since_report <= 32'd0;
    end else if (accept) begin
      auto_send_on      <= auto_send_on_next;
      time_since_report <= time_since_report_next;
    end
  end

  // input register; an item with no reply enters as a bubble
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (advance) begin
      s1_vld <= accept && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_kind    <= kind_next;
      s1_beacon  <= beacon_present;
      s1_heading <= robot_heading;
      s1_fwd     <= delta_forward;
      s1_side    <= delta_side;
    end
  end

  irb_cordic u_cordic (
    .clk     (clk),
    .en      (advance),
    .fwd     (s1_fwd),
    .side    (s1_side),
    .bearing (bearing)
  );

  // side pipeline kept in step with the cordic: squares first, ring tests next
  assign fwd_prod  = s1_fwd * s1_fwd;
  assign side_prod = s1_side * s1_side;
  assign dist_sq   = 32'(side_q[0].fwd_sq) + 32'(side_q[0].side_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < CORDIC_STAGES; j++) begin
        side_q[j].vld <= 1'b0;
      end
    end else if (advance) begin
      side_q[0].vld     <= s1_vld;
      side_q[0].kind    <= s1_kind;
      side_q[0].beacon  <= s1_beacon;
      side_q[0].heading <= s1_heading;
      side_q[0].fwd_sq  <= fwd_prod[30:0];
      side_q[0].side_sq <= side_prod[30:0];
      side_q[0].near    <= 1'b0;
      side_q[0].closer  <= 1'b0;
      side_q[0].closest <= 1'b0;
      for (int j = 1; j < CORDIC_STAGES; j++) begin
        side_q[j].vld     <= side_q[j-1].vld;
        side_q[j].kind    <= side_q[j-1].kind;
        side_q[j].beacon  <= side_q[j-1].beacon;
        side_q[j].heading <= side_q[j-1].heading;
        side_q[j].fwd_sq  <= side_q[j-1].fwd_sq;
        side_q[j].side_sq <= side_q[j-1].side_sq;
      end
      // ring tests on the squared distance, strictly below
      side_q[1].near    <= dist_sq < near_sq;
      side_q[1].closer  <= dist_sq < closer_sq;
      side_q[1].closest <= dist_sq < closest_sq;
      for (int j = 2; j < CORDIC_STAGES; j++) begin
        side_q[j].near    <= side_q[j-1].near;
        side_q[j].closer  <= side_q[j-1].closer;
        side_q[j].closest <= side_q[j-1].closest;
      end
    end
  end

  // relative bearing and centre receiver
  assign last      = side_q[CORDIC_STAGES-1];
  assign heading_w = {last.heading, 16'd0};
  assign rel_angle = bearing[31 -: ANGLE_BITS] - heading_w[31 -: ANGLE_BITS];
  assign centre    = rel_angle[ANGLE_BITS-1 -: 4];

  // pattern around receiver 0, then rotated onto the centre receiver
  always_comb begin
    pattern     = 16'd1;
    pattern[1]  = last.near;
    pattern[15] = last.near;
    pattern[2]  = last.closer;
    pattern[14] = last.closer;
    pattern[3]  = last.closest;
    pattern[13] = last.closest;
    rotated     = {pattern, pattern} << centre;
    mask        = last.beacon ? rotated[31:16] : 16'd0;
  end

  // reply register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      reply_kind <= last.kind;
      case (last.kind)
        KIND_PONG: begin
          byte_count   <= 2'd1;
          payload_low  <= PONG_BYTE;
          payload_high <= 8'd0;
        end
        KIND_STATE: begin
          byte_count   <= 2'd2;
          payload_low  <= mask[7:0];
          payload_high <= mask[15:8];
        end
        default: begin
          byte_count   <= 2'd0;
          payload_low  <= 8'd0;
          payload_high <= 8'd0;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for ir_beacon_receiver_board_core: a scoreboard class predicts the replies
// depends on irb_pkg and the core; random stimulus, apb register phases and handshake back-pressure
import irb_pkg::*;

localparam logic MODE_FRAME = 1'b0;
localparam logic MODE_TICK  = 1'b1;

typedef struct packed {
  logic               mode;
  logic [7:0]         code;
  logic [7:0]         count;
  logic [7:0]         data;
  logic [15:0]        elapsed;
  logic               beacon;
  logic signed [15:0] fwd;
  logic signed [15:0] side;
  logic [15:0]        heading;
} beacon_item_t;

typedef struct packed {
  logic [1:0] kind;
  logic [1:0] nbytes;
  logic [7:0] lo;
  logic [7:0] hi;
} board_reply_t;

// keeps its own copy of the board state and the replies still owed
class reply_scoreboard;
  logic         auto_send;
  logic [31:0]  time_sum;
  logic [15:0]  period_ms;
  logic [15:0]  near_mm;
  logic [15:0]  closer_mm;
  logic [15:0]  closest_mm;
  board_reply_t replies_due[$];
  int           mismatches;

  function new();
    auto_send  = 1'b0;
    time_sum   = '0;
    period_ms  = PERIOD_RESET;
    near_mm    = NEAR_RESET;
    closer_mm  = CLOSER_RESET;
    closest_mm = CLOSEST_RESET;
    mismatches = 0;
  endfunction

  function void set_register(logic [1:0] idx, logic [15:0] value);
    case (idx)
      REG_PERIOD:  period_ms  = value;
      REG_NEAR:    near_mm    = value;
      REG_CLOSER:  closer_mm  = value;
      REG_CLOSEST: closest_mm = value;
      default: ;
    endcase
  endfunction

  function void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // vectoring cordic, angle in 2^-32 turn
  function logic [31:0] beacon_bearing(longint fwd, longint side);
    logic [31:0] atan_turns [24];
    longint      x;
    longint      y;
    longint      xs;
    longint      ys;
    logic [31:0] z;
    atan_turns = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    if (fwd == 0 && side == 0) return 32'h0;
    x = fwd * 64'sd16777216;
    y = side * 64'sd16777216;
    z = 32'h0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_turns[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_turns[i];
      end
    end
    return z;
  endfunction

  // the two receivers k places either side of the centre, wrapping round the board
  function logic [15:0] ring_pair(logic [3:0] centre, logic [3:0] k);
    logic [15:0] bits;
    logic [3:0]  up;
    logic [3:0]  down;
    bits = '0;
    up = centre + k;
    down = centre - k;
    bits[up] = 1'b1;
    bits[down] = 1'b1;
    return bits;
  endfunction

  function board_reply_t receiver_state(beacon_item_t it);
    longint      fwd;
    longint      side;
    longint      dist_sq;
    logic [31:0] bearing;
    logic [15:0] rel;
    logic [15:0] lit;
    logic [3:0]  centre;
    lit = '0;
    if (it.beacon) begin
      fwd = longint'(it.fwd);
      side = longint'(it.side);
      bearing = beacon_bearing(fwd, side);
      rel = bearing[31:16] - it.heading;
      centre = rel[15:12];
      dist_sq = fwd * fwd + side * side;
      lit[centre] = 1'b1;
      if (dist_sq < longint'(near_mm) * longint'(near_mm))
        lit = lit | ring_pair(centre, 4'd1);
      if (dist_sq < longint'(closer_mm) * longint'(closer_mm))
        lit = lit | ring_pair(centre, 4'd2);
      if (dist_sq < longint'(closest_mm) * longint'(closest_mm))
        lit = lit | ring_pair(centre, 4'd3);
    end
    return '{KIND_STATE, 2'd2, lit[7:0], lit[15:8]};
  endfunction

  function void note_item(beacon_item_t it);
    logic [32:0] sum;
    if (it.mode == MODE_TICK) begin
      if (!auto_send) return;
      sum = {1'b0, time_sum} + {17'h0, it.elapsed};
      time_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      if (time_sum > {16'h0, period_ms}) begin
        time_sum = '0;
        replies_due.push_back(receiver_state(it));
      end
    end else if (it.code == CMD_PING && it.count == 8'd1 && it.data == PING_BYTE) begin
      replies_due.push_back('{KIND_PONG, 2'd1, PONG_BYTE, 8'h00});
    end else if (it.code == CMD_STATE && it.count == 8'd1) begin
      replies_due.push_back(receiver_state(it));
    end else if (it.code == CMD_AUTO && it.count == 8'd1) begin
      auto_send = (it.data == AUTO_ON);
    end else begin
      replies_due.push_back('{KIND_REJECT, 2'd0, 8'h00, 8'h00});
    end
  endfunction

  function void check_reply(board_reply_t got);
    board_reply_t want;
    if (replies_due.size() == 0) begin
      flag($sformatf("unexpected reply: kind %0d bytes %0d low %02h high %02h",
                     got.kind, got.nbytes, got.lo, got.hi));
      return;
    end
    want = replies_due.pop_front();
    if (got !== want)
      flag($sformatf("reply mismatch: expected kind %0d bytes %0d low %02h high %02h, got kind %0d bytes %0d low %02h high %02h",
                     want.kind, want.nbytes, want.lo, want.hi,
                     got.kind, got.nbytes, got.lo, got.hi));
  endfunction

  function int outstanding();
    return replies_due.size();
  endfunction

  function bit all_clear();
    if (replies_due.size() != 0)
      flag($sformatf("%0d replies never arrived", replies_due.size()));
    return mismatches == 0;
  endfunction
endclass

module tb;

  // cycles with no transaction on either channel before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  // extra idle time after the last owed reply before touching registers
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 mode = 1'b0;
  logic [7:0]           command_code = '0;
  logic [7:0]           data_count = '0;
  logic [7:0]           first_data = '0;
  logic [15:0]          elapsed_ms = '0;
  logic                 beacon_present = 1'b0;
  logic signed [15:0]   delta_forward = '0;
  logic signed [15:0]   delta_side = '0;
  logic [15:0]          robot_heading = '0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           reply_kind;
  logic [1:0]           byte_count;
  logic [7:0]           payload_low;
  logic [7:0]           payload_high;

  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  reply_scoreboard sb;

  // idling control: calm flags switch the random gaps off for a stretch
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  ir_beacon_receiver_board_core dut (.*);

  // receiver side: random back-pressure, plus a long hold-off when asked for,
  // counted down here so the sender keeps offering and the pipeline fills
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= receiver_calm || ($urandom_range(99) >= 35);
    end
  end

  // monitor: every accepted transaction goes to the scoreboard; the watchdog
  // ends the run if neither channel moves for too long
  always @(posedge clk) begin : monitor
    beacon_item_t seen;
    board_reply_t got;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen = '{mode, command_code, data_count, first_data, elapsed_ms,
                 beacon_present, delta_forward, delta_side, robot_heading};
        sb.note_item(seen);
      end
      if (out_valid && out_ready) begin
        got = '{reply_kind, byte_count, payload_low, payload_high};
        sb.check_reply(got);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL ir_beacon_receiver_board_core");
        $finish;
      end
    end
  end

  function automatic beacon_item_t mk(logic m, logic [7:0] code, logic [7:0] cnt,
                                      logic [7:0] d, logic [15:0] el, logic b,
                                      logic [15:0] f, logic [15:0] s, logic [15:0] h);
    return '{m, code, cnt, d, el, b, f, s, h};
  endfunction

  // mostly well-formed frames and ticks with random content, some noise
  function automatic beacon_item_t random_item();
    beacon_item_t it;
    int           sel;
    it = '{1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
           1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    sel = $urandom_range(99);
    it.mode = MODE_FRAME;
    it.count = 8'd1;
    if (sel < 20) begin
      it.code = CMD_PING;
      if ($urandom_range(9) != 0) it.data = PING_BYTE;
    end else if (sel < 50) begin
      it.code = CMD_STATE;
    end else if (sel < 58) begin
      it.code = CMD_AUTO;
      if ($urandom_range(3) != 0) it.data = AUTO_ON;
    end else if (sel < 92) begin
      it.mode = MODE_TICK;
      if ($urandom_range(3) != 0)
        it.elapsed = 16'($urandom_range(0, 32'(sb.period_ms)));
    end else begin
      it.code = 8'($urandom_range(0, 4));
      if ($urandom_range(1) == 0) it.code = 8'($urandom);
      it.count = 8'($urandom);
    end
    // broken length now and then
    if (it.mode == MODE_FRAME && $urandom_range(11) == 0) it.count = 8'($urandom);
    it.beacon = ($urandom_range(99) < 85);
    if ($urandom_range(9) < 6) begin
      it.fwd = 16'($urandom_range(0, 6000)) - 16'd3000;
      it.side = 16'($urandom_range(0, 6000)) - 16'd3000;
    end
    if ($urandom_range(19) == 0) begin
      it.fwd = '0;
      it.side = '0;
    end
    return it;
  endfunction

  // offer one transaction and hold it until the core takes it
  task automatic send_item(input beacon_item_t it);
    if (!sender_calm) begin
      while ($urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    mode           <= it.mode;
    command_code   <= it.code;
    data_count     <= it.count;
    first_data     <= it.data;
    elapsed_ms     <= it.elapsed;
    beacon_present <= it.beacon;
    delta_forward  <= it.fwd;
    delta_side     <= it.side;
    robot_heading  <= it.heading;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering until every owed reply is in, then let the pipeline drain
  task automatic settle_board(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // setup and access phase write, then a read back of the same register
  task automatic apb_write(input logic [1:0] idx, input logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== value)
      sb.flag($sformatf("register %0d read back %04h, expected %04h", idx, prdata[15:0], value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(input logic [15:0] period, input logic [15:0] near,
                               input logic [15:0] closer, input logic [15:0] closest);
    settle_board(SETTLE_CYCLES);
    apb_write(REG_PERIOD, period);
    apb_write(REG_NEAR, near);
    apb_write(REG_CLOSER, closer);
    apb_write(REG_CLOSEST, closest);
  endtask

  // random phase; hold_at starts the receiver hold-off with a gap-free sender,
  // pause_at waits for every owed reply before going on
  task automatic run_random(input int n, input int hold_at, input int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) begin
        hold_req = 1'b1;
        sender_calm = 1'b1;
      end
      if (i == hold_at + 30) sender_calm = 1'b0;
      if (i == pause_at) settle_board(0);
      send_item(random_item());
    end
    sender_calm = 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part, registers at their defaults
    send_item(mk(MODE_FRAME, CMD_PING, 8'd1, PING_BYTE, 16'h0, 1'b0, 16'h0, 16'h0, 16'h0));
    send_item(mk(MODE_FRAME, CMD_PING, 8'd1, 8'h54, 16'h0, 1'b0, 16'h0, 16'h0, 16'h0));
    send_item(mk(MODE_FRAME, CMD_PING, 8'd0, PING_BYTE, 16'h0, 1'b0, 16'h0, 16'h0, 16'h0));
    send_item(mk(MODE_FRAME, CMD_PING, 8'hFF, PING_BYTE, 16'hFFFF, 1'b1, 16'h0, 16'h0, 16'h0));
    // unknown command codes
    send_item(mk(MODE_FRAME, 8'd3, 8'd1, 8'h00, 16'h0, 1'b1, 16'h0, 16'h0, 16'h0));
    send_item(mk(MODE_FRAME, 8'hFF, 8'd1, 8'hFF, 16'h0, 1'b1, 16'h0, 16'h0, 16'h0));
    // state requests: no beacon, zero delta, extremes of both deltas and the heading
    send_item(mk(MODE_FRAME, CMD_STATE, 8'd1, 8'h00, 16'h0, 1'b0, 16'h0100, 16'h0100, 16'h0));
    send_item(mk(MODE_FRAME, CMD_STATE, 8'd1, 8'h00, 16'h0, 1'b1, 16'h0, 16'h0, 16'h0));
    send_item(mk(MODE_FRAME, CMD_STATE, 8'd1, 8'h00, 16'h0, 1'b1, 16'h7FFF, 16'h7FFF, 16'hFFFF));
    send_item(mk(MODE_FRAME, CMD_STATE, 8'd1, 8'h00, 16'h0, 1'b1, 16'h8000, 16'h8000, 16'h0));
    send_item(mk(MODE_FRAME, CMD_STATE, 8'd1, 8'h00, 16'h0, 1'b1, 16'h8000, 16'h0, 16'h4000));
    send_item(mk(MODE_FRAME, CMD_STATE, 8'd1, 8'h00, 16'h0, 1'b1, 16'h0, 16'h8000, 16'h8000));
    send_item(mk(MODE_FRAME, CMD_STATE, 8'd1, 8'h00, 16'h0, 1'b1, 16'h0, 16'h7FFF, 16'h0));
    // one millimetre behind: every ring lit
    send_item(mk(MODE_FRAME, CMD_STATE, 8'd1, 8'h00, 16'h0, 1'b1, 16'hFFFF, 16'h0, 16'h1234));
    send_item(mk(MODE_FRAME, CMD_STATE, 8'd2, 8'h00, 16'h0, 1'b1, 16'h0, 16'h0, 16'h0));
    // ticks while auto-send is off are ignored
    send_item(mk(MODE_TICK, 8'h00, 8'h00, 8'h00, 16'hFFFF, 1'b1, 16'h0, 16'h0, 16'h0));
    send_item(mk(MODE_FRAME, CMD_AUTO, 8'd0, AUTO_ON, 16'h0, 1'b0, 16'h0, 16'h0, 16'h0));
    send_item(mk(MODE_FRAME, CMD_AUTO, 8'd1, AUTO_ON, 16'h0, 1'b0, 16'h0, 16'h0, 16'h0));
    // sum reaching the period exactly does not fire, one more does
    send_item(mk(MODE_TICK, 8'h00, 8'h00, 8'h00, 16'd100, 1'b1, 16'd300, 16'd300, 16'h0));
    send_item(mk(MODE_TICK, 8'h00, 8'h00, 8'h00, 16'd100, 1'b1, 16'd300, 16'd300, 16'h0));
    send_item(mk(MODE_TICK, 8'h00, 8'h00, 8'h00, 16'd1, 1'b1, 16'd300, 16'hFED4, 16'h0));
    send_item(mk(MODE_TICK, 8'h00, 8'h00, 8'h00, 16'd0, 1'b1, 16'h0, 16'h0, 16'h0));
    send_item(mk(MODE_TICK, 8'h00, 8'h00, 8'h00, 16'hFFFF, 1'b0, 16'h0, 16'h0, 16'h0));
    // any data byte other than one switches auto-send off
    send_item(mk(MODE_FRAME, CMD_AUTO, 8'd1, 8'd2, 16'h0, 1'b0, 16'h0, 16'h0, 16'h0));
    send_item(mk(MODE_TICK, 8'h00, 8'h00, 8'h00, 16'hFFFF, 1'b1, 16'h0, 16'h0, 16'h0));

    // shortest period, widest rings; receiver hold-off midway
    apply_setting(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(90, 40, -1);

    // longest period, rings shut; sender waits for the pipeline to empty midway
    apply_setting(16'hFFFF, 16'h0, 16'h0, 16'h0);
    run_random(90, -1, 45);

    // random moderate setting
    apply_setting(16'($urandom_range(1, 400)), 16'($urandom_range(0, 4000)),
                  16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)));
    run_random(90, 60, 20);

    // defaults again with no receiver idling; the sender is gap-free for its first 29 items
    apply_setting(PERIOD_RESET, NEAR_RESET, CLOSER_RESET, CLOSEST_RESET);
    sender_calm = 1'b1;
    receiver_calm = 1'b1;
    run_random(90, -1, -1);
    receiver_calm = 1'b0;

    // fully random setting
    apply_setting(16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(90, 10, 70);

    settle_board(20);
    if (sb.all_clear())
      $display("PASS ir_beacon_receiver_board_core");
    else
      $display("FAIL ir_beacon_receiver_board_core");
    $finish;
  end

endmodule
